// ===== sv/ilc_pkg.sv =====
// Package for the int16 linear convolution block.
// Holds the command and status structs shared by the controller, the datapath
// and the top level. No dependencies.
package ilc_pkg;

   localparam int SAMPLE_W = 16;

   localparam logic MODE_TAP    = 1'b0;
   localparam logic MODE_SAMPLE = 1'b1;

   typedef struct packed {
      logic load_tap;
      logic start;
      logic step;
      logic drain;
      logic emit;
      logic flush_start;
   } cmd_type;

   typedef struct packed {
      logic no_taps;
      logic last_step;
      logic flush_done;
      logic rsp_free;
   } status_type;

endpackage

// ===== sv/int16_linear_convolution.sv =====
// Top level of the int16 linear convolution block: controller plus datapath.
// Depends on ilc_pkg, ilc_ctrl, ilc_datapath and ilc_ram.
//
// Requests with tuser 0 load kernel taps in order; the tap marked with tlast
// sets the kernel length L, and taps beyond MAX_TAPS are dropped. A request
// with tuser 1 is a sample and yields one output, the low 16 bits of the sum
// of h[k]*x[n-k]. A sample with tlast also yields L-1 flush outputs computed
// with zero input, marks the final one with tlast and then clears the sample
// history. A single multiplier walks the taps one per cycle from the tap and
// history memories; a new request is accepted while a result still waits in
// the output register.
module int16_linear_convolution #(
   parameter int MAX_TAPS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // value[15:0]
   input  logic        req_tuser,   // mode
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // result_value[15:0]
   output logic        rsp_tlast
);

   ilc_pkg::cmd_type    cmd;
   ilc_pkg::status_type status;

   ilc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_mode  (req_tuser),
      .status    (status),
      .cmd       (cmd)
   );

   ilc_datapath #(.MAX_TAPS(MAX_TAPS)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_value (req_tdata),
      .req_last  (req_tlast),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_value (rsp_tdata),
      .rsp_last  (rsp_tlast)
   );

   a_emit_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.rsp_free)
      else $error("Result loaded while the output register is still occupied.");

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_tap, cmd.start, cmd.step, cmd.drain, cmd.emit}))
      else $error("More than one datapath command issued in a cycle.");

   a_flush_with_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.flush_start |-> cmd.emit && !status.flush_done)
      else $error("Flush pass started without emitting the previous output.");

   a_busy_after_sample: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == ilc_pkg::MODE_SAMPLE |=> !req_tready)
      else $error("Request accepted while a sample is being processed.");

endmodule

// ===== sv/ilc_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// Used for the tap store and the sample history. No dependencies.
module ilc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/ilc_datapath.sv =====
// Datapath of the int16 linear convolution block: tap and history memories,
// the multiply-accumulate unit, the counters and the result register.
// Depends on ilc_pkg and ilc_ram.
module ilc_datapath #(
   parameter int MAX_TAPS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ilc_pkg::cmd_type              cmd,
   output ilc_pkg::status_type           status,
   input  logic [ilc_pkg::SAMPLE_W-1:0]  req_value,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ilc_pkg::SAMPLE_W-1:0]  rsp_value,
   output logic                          rsp_last
);

   localparam int CW   = $clog2(MAX_TAPS + 1);
   localparam int AW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int SW   = ilc_pkg::SAMPLE_W;
   localparam int HMAX = MAX_TAPS - 1;

   logic [CW-1:0] tap_count_ff, tap_count_in;
   logic [CW-1:0] load_index_ff, load_index_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] k_ff, k_in;
   logic [CW-1:0] flush_ff, flush_in;
   logic [AW-1:0] wp_ff, wp_in;
   logic [AW-1:0] ra_ff, ra_in;
   logic [SW-1:0] x_ff, x_in;
   logic          last_ff, last_in;
   logic [SW-1:0] acc_ff, acc_in;
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_use_x_ff, s1_use_x_in;
   logic          s1_hist_ok_ff, s1_hist_ok_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0] rsp_value_ff, rsp_value_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          tap_wr_en;
   logic [SW-1:0] tap_rd;
   logic [SW-1:0] hist_rd;
   logic [SW-1:0] operand;
   logic [2*SW-1:0] product;
   logic          final_out;

   ilc_ram #(.WIDTH(SW), .DEPTH(MAX_TAPS)) u_tap_ram (
      .clock   (clock),
      .wr_en   (tap_wr_en),
      .wr_addr (load_index_ff[AW-1:0]),
      .wr_data (req_value),
      .rd_addr (k_ff[AW-1:0]),
      .rd_data (tap_rd)
   );

   ilc_ram #(.WIDTH(SW), .DEPTH(MAX_TAPS)) u_hist_ram (
      .clock   (clock),
      .wr_en   (cmd.drain),
      .wr_addr (wp_ff),
      .wr_data (x_ff),
      .rd_addr (ra_ff),
      .rd_data (hist_rd)
   );

   assign tap_wr_en = cmd.load_tap && (load_index_ff < CW'(MAX_TAPS));
   assign operand   = s1_use_x_ff ? x_ff : (s1_hist_ok_ff ? hist_rd : '0);
   assign product   = $signed(tap_rd) * $signed(operand);
   assign final_out = last_ff && (flush_ff == '0);

   always_comb begin
      tap_count_in  = tap_count_ff;
      load_index_in = load_index_ff;
      fill_in       = fill_ff;
      k_in          = k_ff;
      flush_in      = flush_ff;
      wp_in         = wp_ff;
      ra_in         = ra_ff;
      x_in          = x_ff;
      last_in       = last_ff;
      acc_in        = acc_ff;
      s1_valid_in   = cmd.step;
      s1_use_x_in   = (k_ff == '0);
      s1_hist_ok_in = (k_ff <= fill_ff);
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;

      if (cmd.load_tap) begin
         if (tap_wr_en) begin
            load_index_in = load_index_ff + CW'(1);
         end
         if (req_last) begin
            tap_count_in  = load_index_in;
            load_index_in = '0;
         end
      end

      if (s1_valid_ff) begin
         acc_in = acc_ff + product[SW-1:0];
      end

      if (cmd.start) begin
         x_in     = req_value;
         last_in  = req_last;
         k_in     = '0;
         ra_in    = wp_ff;
         acc_in   = '0;
         flush_in = (req_last && tap_count_ff != '0) ? tap_count_ff - CW'(1) : '0;
      end

      if (cmd.step) begin
         k_in  = k_ff + CW'(1);
         ra_in = (ra_ff == '0) ? AW'(MAX_TAPS - 1) : ra_ff - AW'(1);
      end

      if (cmd.drain) begin
         wp_in = (wp_ff == AW'(MAX_TAPS - 1)) ? '0 : wp_ff + AW'(1);
         if (fill_ff < CW'(HMAX)) begin
            fill_in = fill_ff + CW'(1);
         end
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = acc_ff;
         rsp_last_in  = final_out;
         if (final_out) begin
            fill_in = '0;
         end
      end

      if (cmd.flush_start) begin
         x_in     = '0;
         k_in     = '0;
         ra_in    = wp_ff;
         acc_in   = '0;
         flush_in = flush_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff  <= '0;
         load_index_ff <= '0;
         fill_ff       <= '0;
         k_ff          <= '0;
         flush_ff      <= '0;
         wp_ff         <= '0;
         ra_ff         <= '0;
         last_ff       <= 1'b0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         tap_count_ff  <= tap_count_in;
         load_index_ff <= load_index_in;
         fill_ff       <= fill_in;
         k_ff          <= k_in;
         flush_ff      <= flush_in;
         wp_ff         <= wp_in;
         ra_ff         <= ra_in;
         last_ff       <= last_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      x_ff          <= x_in;
      acc_ff        <= acc_in;
      s1_use_x_ff   <= s1_use_x_in;
      s1_hist_ok_ff <= s1_hist_ok_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign status.no_taps    = (tap_count_ff == '0);
   assign status.last_step  = ((k_ff + CW'(1)) == tap_count_ff);
   assign status.flush_done = (flush_ff == '0);
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

// ===== sv/ilc_ctrl.sv =====
// Controller of the int16 linear convolution block: sequences tap loads,
// the multiply-accumulate passes, history updates and flush outputs.
// Depends on ilc_pkg.
module ilc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_mode,
   input  ilc_pkg::status_type status,
   output ilc_pkg::cmd_type    cmd
);

   typedef enum logic [1:0] {
      IDLE,
      RUN,
      DRAIN,
      EMIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_mode == ilc_pkg::MODE_SAMPLE) begin
                  cmd.start = 1'b1;
                  state_in  = status.no_taps ? DRAIN : RUN;
               end else begin
                  cmd.load_tap = 1'b1;
               end
            end
         end
         RUN: begin
            cmd.step = 1'b1;
            if (status.last_step) begin
               state_in = DRAIN;
            end
         end
         DRAIN: begin
            cmd.drain = 1'b1;
            state_in  = EMIT;
         end
         EMIT: begin
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               if (status.flush_done) begin
                  state_in = IDLE;
               end else begin
                  cmd.flush_start = 1'b1;
                  state_in        = RUN;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for int16_linear_convolution: directed and random requests.
// Keeps its own model of the tap store and sample history to predict every output.
// Depends on ilc_pkg and the int16_linear_convolution top level.
`timescale 1ns / 1ps

module testbench;

   localparam int DATA_W      = ilc_pkg::SAMPLE_W;
   localparam int TAP_DEPTH   = 32;
   localparam int ITEM_TARGET = 230;
   localparam int HOLD_CYCLES = 400;
   localparam int WATCH_LIMIT = 4000;
   localparam int DRAIN_WAIT  = 100;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              last;
   } conv_output_type;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata  = '0;
   logic              req_tuser  = ilc_pkg::MODE_TAP;
   logic              req_tlast  = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;
   logic              rsp_tlast;

   logic signed [DATA_W-1:0] tap_mem [TAP_DEPTH];
   logic signed [DATA_W-1:0] history [TAP_DEPTH-1];
   int                       kernel_len = 0;
   int                       load_pos   = 0;
   conv_output_type          expected_outputs [$];

   int   error_count   = 0;
   int   requests_sent = 0;
   logic idle_on       = 1'b1;
   int   stall_token   = 0;
   int   stall_seen    = 0;
   int   hold_left     = 0;
   int   quiet_cycles  = 0;

   int16_linear_convolution #(
      .MAX_TAPS(TAP_DEPTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),     // value[15:0]
      .req_tuser(req_tuser),     // mode
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),     // result_value[15:0]
      .rsp_tlast(rsp_tlast)
   );

   always #10 clock = ~clock;

   function automatic logic [DATA_W-1:0] convolve_sample(input logic signed [DATA_W-1:0] x);
      logic [DATA_W-1:0]  acc;
      logic signed [31:0] prod;
      acc = '0;
      if (kernel_len > 0) begin
         prod = tap_mem[0] * x;
         acc  = acc + prod[DATA_W-1:0];
         for (int k = 1; k < kernel_len; k++) begin
            prod = tap_mem[k] * history[k-1];
            acc  = acc + prod[DATA_W-1:0];
         end
      end
      for (int k = TAP_DEPTH - 2; k > 0; k--) begin
         history[k] = history[k-1];
      end
      history[0] = x;
      return acc;
   endfunction

   task automatic absorb_request(input logic mode, input logic [DATA_W-1:0] value,
                                 input logic last);
      int              count;
      conv_output_type item;
      if (mode == ilc_pkg::MODE_TAP) begin
         if (load_pos < TAP_DEPTH) begin
            tap_mem[load_pos] = value;
            load_pos++;
         end
         if (last) begin
            kernel_len = load_pos;
            load_pos   = 0;
         end
      end else begin
         count = (last && kernel_len > 1) ? kernel_len : 1;
         for (int i = 0; i < count; i++) begin
            item.value = convolve_sample((i == 0) ? value : '0);
            item.last  = last && (i == count - 1);
            expected_outputs.push_back(item);
         end
         if (last) begin
            for (int k = 0; k < TAP_DEPTH - 1; k++) begin
               history[k] = '0;
            end
         end
      end
   endtask

   initial begin
      for (int k = 0; k < TAP_DEPTH - 1; k++) begin
         history[k] = '0;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         absorb_request(req_tuser, req_tdata, req_tlast);
      end
   end

   always @(posedge clock) begin
      conv_output_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_outputs.size() == 0) begin
            $error("unexpected result: result_value %h, result_last %b", rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            want = expected_outputs.pop_front();
            if (rsp_tdata !== want.value) begin
               $error("result_value: expected %h, actual %h", want.value, rsp_tdata);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("result_last: expected %b, actual %b", want.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (stall_seen != stall_token) begin
         stall_seen <= stall_token;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (idle_on) begin
         rsp_tready <= ($urandom_range(0, 99) >= 23);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCH_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_request(input logic mode, input logic [DATA_W-1:0] value,
                               input logic last);
      while (idle_on && $urandom_range(0, 99) < 23) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= value;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests_sent++;
   endtask

   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'hffff;
         default: return DATA_W'($urandom);
      endcase
   endfunction

   function automatic int pick_kernel_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 6);
      if (r < 88) return $urandom_range(7, 31);
      return $urandom_range(32, 36);
   endfunction

   // Samples sent before any kernel is loaded must all give zero.
   task automatic test_no_kernel();
      send_request(ilc_pkg::MODE_SAMPLE, 16'h7fff, 1'b0);
      send_request(ilc_pkg::MODE_SAMPLE, 16'h8000, 1'b1);
   endtask

   task automatic test_single_tap();
      send_request(ilc_pkg::MODE_TAP, 16'h8000, 1'b1);
      send_request(ilc_pkg::MODE_SAMPLE, 16'h8000, 1'b0);
      send_request(ilc_pkg::MODE_SAMPLE, 16'h7fff, 1'b1);
   endtask

   task automatic test_extremes();
      send_request(ilc_pkg::MODE_TAP, 16'h7fff, 1'b0);
      send_request(ilc_pkg::MODE_TAP, 16'h8000, 1'b0);
      send_request(ilc_pkg::MODE_TAP, 16'hffff, 1'b1);
      send_request(ilc_pkg::MODE_SAMPLE, 16'h7fff, 1'b0);
      send_request(ilc_pkg::MODE_SAMPLE, 16'h8000, 1'b0);
      send_request(ilc_pkg::MODE_SAMPLE, 16'h0000, 1'b0);
      send_request(ilc_pkg::MODE_SAMPLE, 16'hffff, 1'b1);
   endtask

   // A sample in the middle of a kernel reload uses the old length with the new first tap.
   task automatic test_reload_midstream();
      send_request(ilc_pkg::MODE_TAP, 16'h0005, 1'b0);
      send_request(ilc_pkg::MODE_TAP, 16'hfffd, 1'b1);
      send_request(ilc_pkg::MODE_SAMPLE, 16'h0064, 1'b0);
      send_request(ilc_pkg::MODE_TAP, 16'h0007, 1'b0);
      send_request(ilc_pkg::MODE_SAMPLE, 16'h00c8, 1'b0);
      send_request(ilc_pkg::MODE_TAP, 16'h0009, 1'b1);
      send_request(ilc_pkg::MODE_SAMPLE, 16'hffff, 1'b1);
   endtask

   task automatic test_random();
      int seq;
      int taps;
      int samples;
      seq = 0;
      while (requests_sent < ITEM_TARGET) begin
         idle_on = !(seq >= 8 && seq < 14);
         if (seq == 0 || $urandom_range(0, 99) < 85) begin
            taps = (seq == 0) ? TAP_DEPTH + 1 : pick_kernel_len();
            for (int i = 0; i < taps; i++) begin
               send_request(ilc_pkg::MODE_TAP, pick_value(), i == taps - 1);
            end
            if (seq == 4) begin
               stall_token++;
            end
            samples = (seq == 4) ? 12 : $urandom_range(1, 10);
            for (int i = 0; i < samples; i++) begin
               if ($urandom_range(0, 99) < 5) begin
                  send_request(ilc_pkg::MODE_TAP, pick_value(), 1'b0);
               end
               send_request(ilc_pkg::MODE_SAMPLE, pick_value(), i == samples - 1);
            end
         end else begin
            repeat ($urandom_range(1, 6)) begin
               send_request(logic'($urandom_range(0, 1)), pick_value(),
                            $urandom_range(0, 99) < 30);
            end
         end
         seq++;
      end
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_no_kernel();
      test_single_tap();
      test_extremes();
      test_reload_midstream();
      test_random();
      req_tvalid <= 1'b0;
      while (expected_outputs.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
